/* src/rvie_pkg.sv */
// Shared constants, codes and types of the register VM instruction executor.
package rvie_pkg;

    // Machine geometry
    localparam int DMEM_BYTES = 4096;
    localparam int DMEM_AW    = $clog2(DMEM_BYTES);
    localparam int PROG_DEPTH = 1024;
    localparam int PC_W       = $clog2(PROG_DEPTH);
    localparam int LEN_W      = 11;
    localparam int NUM_REGS   = 16;
    localparam int RIDX_W     = $clog2(NUM_REGS);
    localparam int XLEN       = 64;
    localparam int CNT_W      = $clog2(XLEN);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Opcodes
    localparam logic [3:0] OP_MOV     = 4'd0;
    localparam logic [3:0] OP_CMP     = 4'd1;
    localparam logic [3:0] OP_ADD     = 4'd2;
    localparam logic [3:0] OP_SUB     = 4'd3;
    localparam logic [3:0] OP_MUL     = 4'd4;
    localparam logic [3:0] OP_DIV     = 4'd5;
    localparam logic [3:0] OP_MOD     = 4'd6;
    localparam logic [3:0] OP_LOAD    = 4'd7;
    localparam logic [3:0] OP_STORE   = 4'd8;
    localparam logic [3:0] OP_PUSH    = 4'd9;
    localparam logic [3:0] OP_POP     = 4'd10;
    localparam logic [3:0] OP_CALL    = 4'd11;
    localparam logic [3:0] OP_JUMP    = 4'd12;
    localparam logic [3:0] OP_JUMPREG = 4'd13;
    localparam logic [3:0] OP_SYSCALL = 4'd14;
    localparam logic [3:0] OP_NOP     = 4'd15;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_BADSYS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = 2'd1;

    // Reset values
    localparam logic [LEN_W-1:0]   RST_PROG_LEN   = 11'd1024;
    localparam logic [DMEM_AW-1:0] RST_STACK_BASE = DMEM_AW'(2048);

    typedef struct packed {
        logic [3:0]      opcode;
        logic [3:0]      dest_reg;
        logic [3:0]      src_a_reg;
        logic [3:0]      src_b_reg;
        logic [63:0]     immediate;
        logic            use_immediate;
        logic [1:0]      access_size;
        logic [15:0]     register_mask;
        logic [PC_W-1:0] jump_target;
    } t_in;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            halted;
        logic            char_valid;
        logic [7:0]      char_out;
        logic [1:0]      status;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_RDB, S_CAPB, S_MUL, S_DIV, S_WRRD,
        S_LDRD, S_LDCAP, S_LDWA, S_WRB, S_ST,
        S_PSCAN, S_PSCAP, S_PSWR,
        S_POSCAN, S_PORD, S_POCAP, S_POWR, S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_CHECK, C_READ_B, C_CAPT_B, C_MUL_STEP, C_DIV_STEP,
        C_WR_RD, C_MEM_RD, C_MEM_CAP, C_LD_WRA, C_WR_BASE, C_ST_BYTE,
        C_READ_IDX, C_PUSH_LOAD, C_PUSH_BYTE, C_IDX_STEP, C_POP_DEC,
        C_POP_WR, C_FINISH
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       halt_path;
        logic       b_zero;
        logic       cnt_last;
        logic       byte_last;
        logic       mask_bit;
        logic       idx_end;
        logic       out_free;
    } t_dp_status;

endpackage

/* src/register_vm_instruction_executor.sv */
// Top level of the register VM instruction executor: controller plus datapath.
// Sequence per word: halted words go straight to the result; nop/cmp/jumps/syscall and zero divide
// read their operands only; mov/add/sub write rd; mul/div/mod run a 64-step loop; load and store
// move one byte at a time, as do push and pop for each register (byte memory port).
// One word is taken at a time; a stalled result holds off the next word.
// Reset is synchronous, active low: pc 0, stack pointer 2048, registers read as zero via valid bits.
module register_vm_instruction_executor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rvie_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rvie_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rvie_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rvie_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rvie_pkg::t_cmd       cmd;
    rvie_pkg::t_dp_status st;

    // Sequencer
    rvie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath
    rvie_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

/* src/rvie_ctrl.sv */
// Controller state machine that sequences each instruction.
module rvie_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rvie_pkg::t_dp_status i_st,
    output rvie_pkg::t_cmd      o_cmd,
    output logic                o_in_stall
);

    rvie_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rvie_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rvie_pkg::S_IDLE:   if (i_in_valid) n_state = rvie_pkg::S_CHECK;
            rvie_pkg::S_CHECK:  n_state = i_st.halt_path ? rvie_pkg::S_FINISH : rvie_pkg::S_RDB;
            rvie_pkg::S_RDB:    n_state = rvie_pkg::S_CAPB;
            rvie_pkg::S_CAPB: begin
                case (i_st.op)
                    rvie_pkg::OP_MOV, rvie_pkg::OP_ADD, rvie_pkg::OP_SUB:
                        n_state = rvie_pkg::S_WRRD;
                    rvie_pkg::OP_MUL:   n_state = rvie_pkg::S_MUL;
                    rvie_pkg::OP_DIV, rvie_pkg::OP_MOD:
                        n_state = i_st.b_zero ? rvie_pkg::S_FINISH : rvie_pkg::S_DIV;
                    rvie_pkg::OP_LOAD:  n_state = rvie_pkg::S_LDRD;
                    rvie_pkg::OP_STORE: n_state = rvie_pkg::S_ST;
                    rvie_pkg::OP_PUSH:  n_state = rvie_pkg::S_PSCAN;
                    rvie_pkg::OP_POP:   n_state = rvie_pkg::S_POSCAN;
                    default:            n_state = rvie_pkg::S_FINISH;
                endcase
            end
            rvie_pkg::S_MUL, rvie_pkg::S_DIV:
                if (i_st.cnt_last) n_state = rvie_pkg::S_WRRD;
            rvie_pkg::S_WRRD:   n_state = rvie_pkg::S_FINISH;
            rvie_pkg::S_LDRD:   n_state = rvie_pkg::S_LDCAP;
            rvie_pkg::S_LDCAP:  n_state = i_st.byte_last ? rvie_pkg::S_LDWA : rvie_pkg::S_LDRD;
            rvie_pkg::S_LDWA:   n_state = rvie_pkg::S_WRB;
            rvie_pkg::S_WRB:    n_state = rvie_pkg::S_FINISH;
            rvie_pkg::S_ST:     if (i_st.byte_last) n_state = rvie_pkg::S_WRB;
            rvie_pkg::S_PSCAN: begin
                if (i_st.mask_bit) n_state = rvie_pkg::S_PSCAP;
                else if (i_st.idx_end) n_state = rvie_pkg::S_FINISH;
            end
            rvie_pkg::S_PSCAP:  n_state = rvie_pkg::S_PSWR;
            rvie_pkg::S_PSWR: begin
                if (i_st.byte_last)
                    n_state = i_st.idx_end ? rvie_pkg::S_FINISH : rvie_pkg::S_PSCAN;
            end
            rvie_pkg::S_POSCAN: begin
                if (i_st.mask_bit) n_state = rvie_pkg::S_PORD;
                else if (i_st.idx_end) n_state = rvie_pkg::S_FINISH;
            end
            rvie_pkg::S_PORD:   n_state = rvie_pkg::S_POCAP;
            rvie_pkg::S_POCAP:  n_state = i_st.byte_last ? rvie_pkg::S_POWR : rvie_pkg::S_PORD;
            rvie_pkg::S_POWR:   n_state = i_st.idx_end ? rvie_pkg::S_FINISH : rvie_pkg::S_POSCAN;
            rvie_pkg::S_FINISH: if (i_st.out_free) n_state = rvie_pkg::S_IDLE;
            default:            n_state = rvie_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = rvie_pkg::C_NONE;
        o_in_stall = (r_state != rvie_pkg::S_IDLE);
        case (r_state)
            rvie_pkg::S_IDLE:   o_cmd = i_in_valid ? rvie_pkg::C_LOAD : rvie_pkg::C_NONE;
            rvie_pkg::S_CHECK:  o_cmd = rvie_pkg::C_CHECK;
            rvie_pkg::S_RDB:    o_cmd = rvie_pkg::C_READ_B;
            rvie_pkg::S_CAPB:   o_cmd = rvie_pkg::C_CAPT_B;
            rvie_pkg::S_MUL:    o_cmd = rvie_pkg::C_MUL_STEP;
            rvie_pkg::S_DIV:    o_cmd = rvie_pkg::C_DIV_STEP;
            rvie_pkg::S_WRRD:   o_cmd = rvie_pkg::C_WR_RD;
            rvie_pkg::S_LDRD, rvie_pkg::S_PORD:   o_cmd = rvie_pkg::C_MEM_RD;
            rvie_pkg::S_LDCAP, rvie_pkg::S_POCAP: o_cmd = rvie_pkg::C_MEM_CAP;
            rvie_pkg::S_LDWA:   o_cmd = rvie_pkg::C_LD_WRA;
            rvie_pkg::S_WRB:    o_cmd = rvie_pkg::C_WR_BASE;
            rvie_pkg::S_ST:     o_cmd = rvie_pkg::C_ST_BYTE;
            rvie_pkg::S_PSCAN:
                o_cmd = i_st.mask_bit ? rvie_pkg::C_READ_IDX : rvie_pkg::C_IDX_STEP;
            rvie_pkg::S_PSCAP:  o_cmd = rvie_pkg::C_PUSH_LOAD;
            rvie_pkg::S_PSWR:   o_cmd = rvie_pkg::C_PUSH_BYTE;
            rvie_pkg::S_POSCAN:
                o_cmd = i_st.mask_bit ? rvie_pkg::C_POP_DEC : rvie_pkg::C_IDX_STEP;
            rvie_pkg::S_POWR:   o_cmd = rvie_pkg::C_POP_WR;
            rvie_pkg::S_FINISH: o_cmd = i_st.out_free ? rvie_pkg::C_FINISH : rvie_pkg::C_NONE;
            default:            o_cmd = rvie_pkg::C_NONE;
        endcase
    end

endmodule

/* src/rvie_dpath.sv */
// Datapath: register file, data memory, shift-add multiplier, divider and result register.
module rvie_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rvie_pkg::t_cmd                     i_cmd,
    input  rvie_pkg::t_in                      i_in_data,
    output rvie_pkg::t_dp_status               o_st,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output rvie_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rvie_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rvie_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int XLEN = rvie_pkg::XLEN;
    localparam int AW   = rvie_pkg::DMEM_AW;

    // Control state
    logic [rvie_pkg::PC_W-1:0]   r_pc;
    logic [AW-1:0]               r_sp;
    logic                        r_halt;
    logic [rvie_pkg::LEN_W-1:0]  r_len;
    logic                        r_out_valid;

    // Working registers
    rvie_pkg::t_in               r_item;
    rvie_pkg::t_out              r_out;
    logic [XLEN-1:0]             r_a, r_b, r_base, r_acc, r_npc;
    logic [AW-1:0]               r_addr;
    logic [rvie_pkg::CNT_W-1:0]  r_cnt;
    logic [rvie_pkg::RIDX_W-1:0] r_idx;
    logic                        r_hpath;
    logic [1:0]                  r_status;
    logic                        r_cval;
    logic [7:0]                  r_cout;

    // Register file with reset-cleared valid bits
    logic [XLEN-1:0]             r_rf [rvie_pkg::NUM_REGS];
    logic [rvie_pkg::NUM_REGS-1:0] r_rf_vld;
    logic [XLEN-1:0]             r_rf_q;

    // Data memory
    logic [7:0]                  r_mem [rvie_pkg::DMEM_BYTES];
    logic [7:0]                  r_mdata;

    logic [rvie_pkg::RIDX_W-1:0] rf_raddr, rf_waddr, idx_nxt;
    logic                        rf_we, mem_we, is_stack, new_halt;
    logic [XLEN-1:0]             rf_wdata, b_now, alu_res;
    logic [7:0]                  mem_wdata;
    logic [2:0]                  nb_m1;
    logic [rvie_pkg::LEN_W-1:0]  eff_len;
    logic [XLEN:0]               div_trial, div_diff;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign eff_len  = (r_len > rvie_pkg::LEN_W'(rvie_pkg::PROG_DEPTH)) ?
                      rvie_pkg::LEN_W'(rvie_pkg::PROG_DEPTH) : r_len;
    assign b_now    = r_item.use_immediate ? r_item.immediate : r_rf_q;
    assign is_stack = (r_item.opcode == rvie_pkg::OP_PUSH) ||
                      (r_item.opcode == rvie_pkg::OP_POP);
    assign idx_nxt  = (r_item.opcode == rvie_pkg::OP_PUSH) ? r_idx - 1'b1 : r_idx + 1'b1;
    assign new_halt = r_hpath || (r_npc == '1) || (r_npc >= XLEN'(eff_len));

    // Restoring divider step: remainder in r_acc, dividend shifts out of r_a
    assign div_trial = {r_acc, r_a[XLEN-1]};
    assign div_diff  = div_trial - {1'b0, r_b};

    // Bytes in this access, minus one
    always_comb begin
        case (r_item.access_size)
            2'd0:    nb_m1 = 3'd0;
            2'd1:    nb_m1 = 3'd1;
            2'd2:    nb_m1 = 3'd3;
            default: nb_m1 = 3'd7;
        endcase
        if (is_stack) nb_m1 = 3'd7;
    end

    // Status to controller
    always_comb begin
        o_st.op        = r_item.opcode;
        o_st.halt_path = r_halt || ({1'b0, r_pc} >= eff_len);
        o_st.b_zero    = (b_now == '0);
        o_st.cnt_last  = (r_cnt == '1);
        o_st.byte_last = (r_cnt[2:0] == nb_m1);
        o_st.mask_bit  = r_item.register_mask[r_idx];
        o_st.idx_end   = (r_item.opcode == rvie_pkg::OP_PUSH) ? (r_idx == '0) : (r_idx == '1);
        o_st.out_free  = !r_out_valid || !i_out_stall;
    end

    // ALU result for the destination write
    always_comb begin
        case (r_item.opcode)
            rvie_pkg::OP_MOV: alu_res = r_item.use_immediate ? r_item.immediate : r_a;
            rvie_pkg::OP_ADD: alu_res = r_a + r_b;
            rvie_pkg::OP_SUB: alu_res = r_a - r_b;
            rvie_pkg::OP_MUL: alu_res = r_acc;
            rvie_pkg::OP_DIV: alu_res = r_a;
            default:          alu_res = r_acc;
        endcase
    end

    // Register file port selection
    always_comb begin
        rf_raddr = r_item.src_a_reg;
        rf_we    = 1'b0;
        rf_waddr = r_item.dest_reg;
        rf_wdata = alu_res;
        case (i_cmd)
            rvie_pkg::C_CHECK:
                rf_raddr = (r_item.opcode == rvie_pkg::OP_SYSCALL) ? '0 : r_item.src_a_reg;
            rvie_pkg::C_READ_B:   rf_raddr = r_item.src_b_reg;
            rvie_pkg::C_READ_IDX: rf_raddr = r_idx;
            rvie_pkg::C_WR_RD:    rf_we = 1'b1;
            rvie_pkg::C_LD_WRA: begin
                rf_we    = 1'b1;
                rf_waddr = r_item.src_a_reg;
                rf_wdata = r_acc;
            end
            rvie_pkg::C_WR_BASE: begin
                rf_we    = 1'b1;
                rf_waddr = r_item.src_b_reg;
                rf_wdata = r_base + XLEN'(r_item.dest_reg);
            end
            rvie_pkg::C_POP_WR: begin
                rf_we    = 1'b1;
                rf_waddr = r_idx;
                rf_wdata = r_acc;
            end
            default: ;
        endcase
    end

    // Memory write port
    assign mem_we    = (i_cmd == rvie_pkg::C_ST_BYTE) || (i_cmd == rvie_pkg::C_PUSH_BYTE);
    assign mem_wdata = r_a[{r_cnt[2:0], 3'b000} +: 8];

    // Register file storage, registered read
    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_waddr] <= rf_wdata;
        r_rf_q <= r_rf_vld[rf_raddr] ? r_rf[rf_raddr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[rf_waddr] <= 1'b1;
        end
    end

    // Data memory, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_addr] <= mem_wdata;
        if (i_cmd == rvie_pkg::C_MEM_RD) r_mdata <= r_mem[r_addr];
    end

    // Architectural control state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_sp        <= rvie_pkg::RST_STACK_BASE;
            r_halt      <= 1'b0;
            r_len       <= rvie_pkg::RST_PROG_LEN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == rvie_pkg::C_FINISH) begin
                r_out_valid <= 1'b1;
                r_pc        <= r_npc[rvie_pkg::PC_W-1:0];
                r_halt      <= new_halt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd == rvie_pkg::C_PUSH_BYTE && o_st.byte_last) r_sp <= r_sp + AW'(8);
            if (i_cmd == rvie_pkg::C_POP_DEC) r_sp <= r_sp - AW'(8);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rvie_pkg::CFG_PROG_LEN:   r_len <= i_cfg_data[rvie_pkg::LEN_W-1:0];
                    rvie_pkg::CFG_STACK_BASE: r_sp  <= AW'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Working registers, driven by the command of the cycle
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rvie_pkg::C_LOAD: r_item <= i_in_data;
            rvie_pkg::C_CHECK: begin
                r_hpath  <= o_st.halt_path;
                r_npc    <= XLEN'(r_pc);
                r_status <= rvie_pkg::ST_OK;
                r_cval   <= 1'b0;
                r_cout   <= '0;
            end
            rvie_pkg::C_READ_B: r_a <= r_rf_q;
            rvie_pkg::C_CAPT_B: begin
                r_base <= r_rf_q;
                r_b    <= b_now;
                r_addr <= AW'(r_rf_q + r_item.immediate);
                r_cnt  <= '0;
                r_acc  <= '0;
                r_idx  <= (r_item.opcode == rvie_pkg::OP_PUSH) ? '1 : '0;
                case (r_item.opcode)
                    rvie_pkg::OP_CALL, rvie_pkg::OP_JUMP:
                        r_npc <= XLEN'(r_item.jump_target) + 1'b1;
                    rvie_pkg::OP_JUMPREG: r_npc <= r_a;
                    default:              r_npc <= XLEN'(r_pc) + 1'b1;
                endcase
                if ((r_item.opcode == rvie_pkg::OP_DIV || r_item.opcode == rvie_pkg::OP_MOD)
                    && b_now == '0) begin
                    r_status <= rvie_pkg::ST_DIV0;
                end
                if (r_item.opcode == rvie_pkg::OP_SYSCALL) begin
                    if (r_item.immediate == '0) begin
                        r_cval <= 1'b1;
                        r_cout <= r_a[7:0];
                    end else begin
                        r_status <= rvie_pkg::ST_BADSYS;
                    end
                end
            end
            rvie_pkg::C_MUL_STEP: begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= {r_a[XLEN-2:0], 1'b0};
                r_b   <= {1'b0, r_b[XLEN-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            rvie_pkg::C_DIV_STEP: begin
                if (!div_diff[XLEN]) begin
                    r_acc <= div_diff[XLEN-1:0];
                    r_a   <= {r_a[XLEN-2:0], 1'b1};
                end else begin
                    r_acc <= div_trial[XLEN-1:0];
                    r_a   <= {r_a[XLEN-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            rvie_pkg::C_MEM_RD: r_addr <= r_addr + 1'b1;
            rvie_pkg::C_MEM_CAP: begin
                r_acc[{r_cnt[2:0], 3'b000} +: 8] <= r_mdata;
                r_cnt <= r_cnt + 1'b1;
            end
            rvie_pkg::C_LD_WRA:
                // loaded value lands first when the target is also the base
                if (r_item.src_a_reg == r_item.src_b_reg) r_base <= r_acc;
            rvie_pkg::C_ST_BYTE: begin
                r_addr <= r_addr + 1'b1;
                r_cnt  <= r_cnt + 1'b1;
            end
            rvie_pkg::C_PUSH_LOAD: begin
                r_a    <= r_rf_q;
                r_addr <= r_sp;
                r_cnt  <= '0;
            end
            rvie_pkg::C_PUSH_BYTE: begin
                r_addr <= r_addr + 1'b1;
                r_cnt  <= r_cnt + 1'b1;
                if (o_st.byte_last) r_idx <= idx_nxt;
            end
            rvie_pkg::C_IDX_STEP: r_idx <= idx_nxt;
            rvie_pkg::C_POP_DEC: begin
                r_addr <= r_sp - AW'(8);
                r_cnt  <= '0;
                r_acc  <= '0;
            end
            rvie_pkg::C_POP_WR: r_idx <= idx_nxt;
            rvie_pkg::C_FINISH: begin
                r_out.next_pc    <= r_npc[rvie_pkg::PC_W-1:0];
                r_out.halted     <= new_halt;
                r_out.char_valid <= r_cval;
                r_out.char_out   <= r_cout;
                r_out.status     <= r_status;
            end
            default: ;
        endcase
    end

endmodule

/* src/rvie_chk.sv */
// Port-level checker for the register VM instruction executor, with its bind.
module rvie_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  rvie_pkg::t_in                   i_in_data,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  rvie_pkg::t_out                  o_out_data
);

    logic r_seen_halt;

    // Remember that a halted result was delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_data.halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // One instruction at a time: busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |-> o_out_data.halted)
        else $error("machine resumed after halt");

    // A printed character comes with good status
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.char_valid |-> o_out_data.status == rvie_pkg::ST_OK)
        else $error("character printed with error status");

endmodule

bind register_vm_instruction_executor rvie_chk u_rvie_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
